[rtl/ljpf_pkg.sv]
package ljpf_pkg;

  localparam int POS_W     = 32;
  localparam int RES_W     = 48;
  localparam int ADDR_W    = 3;
  localparam int APB_W     = 32;
  localparam int MAG_W     = 22;   // folded magnitude below the far limit
  localparam int SQ_W      = 2 * MAG_W;
  localparam int S_W       = SQ_W + 1;
  localparam int QUOT_W    = 37;   // 2^63 / s for s >= 2^27
  localparam int REM_W     = 64;
  localparam int CLOSE_BIT = 27;
  localparam int DM48_W    = MAG_W + 6;
  localparam int PIPE_DEPTH = 53;

  localparam logic [POS_W-1:0] BOX_RESET = 32'd655360;
  localparam logic [RES_W-1:0] POS_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [RES_W-1:0] NEG_MIN   = 48'h8000_0000_0000;
  localparam logic [ADDR_W-1:0] REG_BOX  = 3'd0;

  typedef struct packed {
    logic       far;
    logic       zero;
    logic       close;
    logic [1:0] pos;
    logic [1:0] neg;
  } pair_meta_t;

  // Clip a magnitude to the signed 48-bit range; returns {clipped, value}.
  function automatic logic [RES_W:0] clip_signed(input logic [63:0] mag, input logic neg,
                                                input logic over);
    logic [63:0] limit;
    logic [63:0] m;
    logic        sat;
    limit = neg ? 64'(NEG_MIN) : 64'(POS_MAX);
    sat   = over || (mag > limit);
    m     = sat ? limit : mag;
    return {sat, neg ? RES_W'(64'd0 - m) : RES_W'(m)};
  endfunction

endpackage

[rtl/ljpf_in_if.sv]
interface ljpf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_x;
  logic [31:0] first_y;
  logic [31:0] second_x;
  logic [31:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

[rtl/ljpf_out_if.sv]
interface ljpf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] accel_x;
  logic signed [47:0] accel_y;
  logic signed [47:0] pair_potential;
  logic               saturated;
  logic               zero_distance;

  modport source (output valid, accel_x, accel_y, pair_potential, saturated, zero_distance,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, pair_potential, saturated, zero_distance,
                  output ready);
endinterface

[rtl/lennard_jones_pair_force.sv]
// Channel  Dir  Handshake      Payload
// pair     in   valid/ready    first_x, first_y, second_x, second_y (Q16.16)
// result   out  valid/ready    accel_x, accel_y, pair_potential (Q24.24), flags
// apb      in   psel/penable   box side at address 0
//
// One request enters per cycle while the result is not stalled; its path runs through the
// 37-stage restoring divider for 1/r^2 and a chain of two-stage multipliers.
// Synchronous reset clears all valid bits; box side returns to 10.0.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module lennard_jones_pair_force (
  input  logic                        clk,
  input  logic                        rst,
  ljpf_in_if.sink                     pair,
  ljpf_out_if.source                  result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ljpf_pkg::ADDR_W-1:0] paddr,
  input  logic [ljpf_pkg::APB_W-1:0]  pwdata,
  output logic [ljpf_pkg::APB_W-1:0]  prdata,
  output logic                        pready
);
  import ljpf_pkg::*;

  logic [POS_W-1:0]      box_side;
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;

  // Configuration
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_BOX[ADDR_W-1]) ? box_side : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_side <= BOX_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_BOX[ADDR_W-1]) begin
      box_side <= pwdata;
    end
  end

  // Pipeline control
  assign en         = !vld[PIPE_DEPTH-1] || result.ready;
  assign pair.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], pair.valid};
    end
  end

  // Stage 1: raw separation
  logic [1:0][32:0] raw_d;
  logic [1:0]       s1_neg;
  logic [1:0][31:0] s1_mag;

  assign raw_d[0] = {1'b0, pair.second_x} - {1'b0, pair.first_x};
  assign raw_d[1] = {1'b0, pair.second_y} - {1'b0, pair.first_y};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        s1_neg[a] <= raw_d[a][32];
        s1_mag[a] <= raw_d[a][32] ? 32'(33'd0 - raw_d[a]) : raw_d[a][31:0];
      end
    end
  end

  // Stage 2: minimum image fold
  logic [1:0][32:0] fold_f;
  logic [1:0][31:0] fold_mag;
  logic [1:0]       fold_pos;
  logic [1:0]       fold_neg;
  logic [1:0][31:0] s2_dm;
  logic [1:0]       s2_pos;
  logic [1:0]       s2_neg;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fold_f[a] = {1'b0, box_side} - {1'b0, s1_mag[a]};
      if ({s1_mag[a], 1'b0} > {1'b0, box_side}) begin
        fold_mag[a] = fold_f[a][32] ? 32'(33'd0 - fold_f[a]) : fold_f[a][31:0];
        fold_pos[a] = s1_neg[a] ? (!fold_f[a][32] && fold_f[a] != '0) : fold_f[a][32];
        fold_neg[a] = s1_neg[a] ? fold_f[a][32] : (!fold_f[a][32] && fold_f[a] != '0);
      end else begin
        fold_mag[a] = s1_mag[a];
        fold_pos[a] = !s1_neg[a] && s1_mag[a] != '0;
        fold_neg[a] = s1_neg[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dm  <= fold_mag;
      s2_pos <= fold_pos;
      s2_neg <= fold_neg;
    end
  end

  // Stage 3: squares and 48*|d|
  logic [1:0][SQ_W-1:0]   s3_sq;
  logic [1:0][DM48_W-1:0] s3_dm48;
  logic                   s3_far;
  logic [1:0]             s3_pos;
  logic [1:0]             s3_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        s3_sq[a]   <= s2_dm[a][MAG_W-1:0] * s2_dm[a][MAG_W-1:0];
        s3_dm48[a] <= DM48_W'(s2_dm[a][MAG_W-1:0]) * DM48_W'(48);
      end
      s3_far <= (s2_dm[0][31:MAG_W] != '0) || (s2_dm[1][31:MAG_W] != '0);
      s3_pos <= s2_pos;
      s3_neg <= s2_neg;
    end
  end

  // Stage 4: r^2 and case flags
  logic [S_W-1:0] s4_s;
  pair_meta_t     s4_meta;
  logic [S_W-1:0] divisor;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_s          <= S_W'(s3_sq[0]) + S_W'(s3_sq[1]);
      s4_meta.far   <= s3_far;
      s4_meta.zero  <= (s3_sq[0] == '0) && (s3_sq[1] == '0);
      s4_meta.close <= (S_W'(s3_sq[0]) + S_W'(s3_sq[1])) < (S_W'(1) << CLOSE_BIT);
      s4_meta.pos   <= s3_pos;
      s4_meta.neg   <= s3_neg;
    end
  end

  // Close pairs are overridden later; keep the divider in its range.
  assign divisor = s4_meta.close ? (S_W'(1) << CLOSE_BIT) : s4_s;

  logic [QUOT_W-1:0] u;

  ljpf_div u_div (
    .clk      (clk),
    .en       (en),
    .divisor  (divisor),
    .quotient (u)
  );

  // Side delay lines
  logic [47:0] [$bits(pair_meta_t)-1:0] meta_line;
  logic [46:0][1:0][DM48_W-1:0]         dm48_line;
  logic [5:0][QUOT_W-1:0]               u_line;

  always_ff @(posedge clk) begin
    if (en) begin
      meta_line <= {meta_line[46:0], s4_meta};
      dm48_line <= {dm48_line[45:0], s3_dm48};
      u_line    <= {u_line[4:0], u};
    end
  end

  // Power chain of u = 1/r^2
  logic [2*QUOT_W-1:0]  prod_u2;
  logic [41:0]          u2;
  logic [42+QUOT_W-1:0] prod_u3;
  logic [83:0]          prod_u4;
  logic [46:0]          u3;
  logic [51:0]          u4;
  logic [93:0]          prod_u6;
  logic [61:0]          u6;
  logic [62+QUOT_W-1:0] prod_u7;
  logic [59:0]          u7;

  ljpf_mul #(.AW(QUOT_W), .BW(QUOT_W)) u_mul_u2 (
    .clk(clk), .en(en), .a(u), .b(u), .p(prod_u2)
  );
  assign u2 = prod_u2[72:31];

  ljpf_mul #(.AW(42), .BW(QUOT_W)) u_mul_u3 (
    .clk(clk), .en(en), .a(u2), .b(u_line[1]), .p(prod_u3)
  );
  assign u3 = prod_u3[77:31];

  ljpf_mul #(.AW(42), .BW(42)) u_mul_u4 (
    .clk(clk), .en(en), .a(u2), .b(u2), .p(prod_u4)
  );
  assign u4 = prod_u4[82:31];

  ljpf_mul #(.AW(47), .BW(47)) u_mul_u6 (
    .clk(clk), .en(en), .a(u3), .b(u3), .p(prod_u6)
  );
  assign u6 = prod_u6[92:31];

  ljpf_mul #(.AW(62), .BW(QUOT_W)) u_mul_u7 (
    .clk(clk), .en(en), .a(u6), .b(u_line[5]), .p(prod_u7)
  );
  assign u7 = prod_u7[97:38];

  logic [3:0][46:0] u3_line;
  logic [3:0][51:0] u4_line;
  logic [1:0][61:0] u6_line;

  always_ff @(posedge clk) begin
    if (en) begin
      u3_line <= {u3_line[2:0], u3};
      u4_line <= {u4_line[2:0], u4};
      u6_line <= {u6_line[0], u6};
    end
  end

  // Force factor g and potential difference
  logic [60:0] g;
  logic [62:0] diff;
  logic [61:0] diff_mag;
  logic [59:0] s50_gm;
  logic        s50_gpos;
  logic        s50_gneg;
  logic [55:0] s50_pm;
  logic        s50_pneg;

  assign g        = {1'b0, u7} - 61'(u4_line[3] >> 8);
  assign diff     = {1'b0, u6_line[1]} - 63'(u3_line[3]);
  assign diff_mag = diff[62] ? 62'(63'd0 - diff) : diff[61:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s50_gm   <= g[60] ? 60'(61'd0 - g) : g[59:0];
      s50_gpos <= !g[60] && g != '0;
      s50_gneg <= g[60];
      s50_pm   <= diff_mag[61:6];
      s50_pneg <= diff[62] && diff_mag[61:6] != '0;
    end
  end

  logic [1:0][DM48_W+59:0] prod_acc;

  for (genvar a = 0; a < 2; a++) begin : g_axis
    ljpf_mul #(.AW(DM48_W), .BW(60)) u_mul_acc (
      .clk(clk), .en(en), .a(dm48_line[46][a]), .b(s50_gm), .p(prod_acc[a])
    );
  end

  logic [1:0][55:0] pm_line;
  logic [1:0]       pneg_line;
  logic [1:0]       gpos_line;
  logic [1:0]       gneg_line;

  always_ff @(posedge clk) begin
    if (en) begin
      pm_line   <= {pm_line[0], s50_pm};
      pneg_line <= {pneg_line[0], s50_pneg};
      gpos_line <= {gpos_line[0], s50_gpos};
      gneg_line <= {gneg_line[0], s50_gneg};
    end
  end

  // Final select and clip
  pair_meta_t             fin_meta;
  logic [1:0][63:0]       acc_mag;
  logic [1:0]             acc_over;
  logic [1:0]             acc_neg;
  logic [1:0][RES_W:0]    acc_clip;
  logic [RES_W:0]         pot_clip;
  logic [1:0][RES_W-1:0]  acc_next;
  logic [RES_W-1:0]       pot_next;
  logic                   sat_next;
  logic                   zero_next;
  logic [1:0][RES_W-1:0]  acc;
  logic [RES_W-1:0]       pot;
  logic                   sat;
  logic                   zero;

  assign fin_meta = meta_line[47];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      acc_mag[a]  = prod_acc[a][79:16];
      acc_over[a] = prod_acc[a][DM48_W+59:80] != '0;
      acc_neg[a]  = ((fin_meta.pos[a] && gpos_line[1]) || (fin_meta.neg[a] && gneg_line[1]))
                    && acc_mag[a] != '0;
      acc_clip[a] = clip_signed(acc_mag[a], acc_neg[a], acc_over[a]);
    end
    pot_clip = clip_signed(64'(pm_line[1]), pneg_line[1], 1'b0);

    acc_next  = '0;
    pot_next  = '0;
    sat_next  = 1'b0;
    zero_next = 1'b0;
    if (fin_meta.far) begin
      sat_next = 1'b0;
    end else if (fin_meta.zero) begin
      pot_next  = POS_MAX;
      sat_next  = 1'b1;
      zero_next = 1'b1;
    end else if (fin_meta.close) begin
      for (int a = 0; a < 2; a++) begin
        if (fin_meta.pos[a]) begin
          acc_next[a] = NEG_MIN;
        end else if (fin_meta.neg[a]) begin
          acc_next[a] = POS_MAX;
        end
      end
      pot_next = POS_MAX;
      sat_next = 1'b1;
    end else begin
      acc_next[0] = acc_clip[0][RES_W-1:0];
      acc_next[1] = acc_clip[1][RES_W-1:0];
      pot_next    = pot_clip[RES_W-1:0];
      sat_next    = acc_clip[0][RES_W] || acc_clip[1][RES_W] || pot_clip[RES_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc  <= acc_next;
      pot  <= pot_next;
      sat  <= sat_next;
      zero <= zero_next;
    end
  end

  assign result.valid          = vld[PIPE_DEPTH-1];
  assign result.accel_x        = acc[0];
  assign result.accel_y        = acc[1];
  assign result.pair_potential = pot;
  assign result.saturated      = sat;
  assign result.zero_distance  = zero;

`ifndef SYNTHESIS
  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_distance |-> result.saturated)
    else $error("zero separation without saturation");

  a_zero_vals: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_distance |->
      result.accel_x == '0 && result.accel_y == '0 && result.pair_potential == POS_MAX)
    else $error("zero separation result values wrong");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !pair.ready)
    else $error("request taken while result stalled");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(vld))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");
`endif
endmodule

[rtl/ljpf_mul.sv]
module ljpf_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  logic [63:0]  ax;
  logic [63:0]  bx;
  logic [63:0]  prod_ll;
  logic [63:0]  prod_lh;
  logic [63:0]  prod_hl;
  logic [63:0]  prod_hh;
  logic [127:0] sum;

  assign ax = 64'(a);
  assign bx = 64'(b);

  // Four 32x32 partial products, then one registered sum.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_ll <= ax[31:0] * bx[31:0];
      prod_lh <= ax[31:0] * bx[63:32];
      prod_hl <= ax[63:32] * bx[31:0];
      prod_hh <= ax[63:32] * bx[63:32];
    end
  end

  assign sum = 128'(prod_ll) + (128'(prod_lh) << 32) + (128'(prod_hl) << 32)
             + (128'(prod_hh) << 64);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[AW+BW-1:0];
    end
  end
endmodule

[rtl/ljpf_div.sv]
module ljpf_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ljpf_pkg::S_W-1:0]    divisor,
  output logic [ljpf_pkg::QUOT_W-1:0] quotient
);
  import ljpf_pkg::*;

  localparam int SH_W = S_W + QUOT_W;

  logic [REM_W-1:0]  rem [QUOT_W+1];
  logic [S_W-1:0]    dv  [QUOT_W+1];
  logic [QUOT_W-1:0] q   [QUOT_W+1];

  assign rem[0] = REM_W'(1) << 63;
  assign dv[0]  = divisor;
  assign q[0]   = '0;

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int B = QUOT_W - 1 - k;
    logic [SH_W-1:0] trial;
    logic            take;
    assign trial = SH_W'(dv[k]) << B;
    assign take  = SH_W'(rem[k]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? rem[k] - trial[REM_W-1:0] : rem[k];
        q[k+1]   <= take ? (q[k] | (QUOT_W'(1) << B)) : q[k];
        dv[k+1]  <= dv[k];
      end
    end
  end

  assign quotient = q[QUOT_W];
endmodule
